@@ sv/sensor_average_calibrate_normalize_assert.svh @@
// Assertion macros for the sensor averager
`ifndef SENSOR_AVERAGE_CALIBRATE_NORMALIZE_ASSERT_SVH
`define SENSOR_AVERAGE_CALIBRATE_NORMALIZE_ASSERT_SVH

// same-cycle implication
`define SACN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sacn assertion failed");

// next-cycle implication
`define SACN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sacn assertion failed");

`endif

@@ sv/sacn_pkg.sv @@
package sacn_pkg;

   localparam int CHANNELS   = 6;
   localparam int CH_W       = 3;
   localparam int VALUE_W    = 12;
   localparam int DIFF_OUT_W = 14;
   localparam int RSP_W      = 104;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LAST  = 2'd2;

   localparam logic [1:0] MODE_CAL = 2'd0;
   localparam logic [1:0] MODE_RUN = 2'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ sv/sacn_div.sv @@
module sacn_div #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [NUM_W-1:0]     quo,
   output sacn_pkg::div_stat_type stat
);
   import sacn_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            num_ff <= num_ff << 1;
            rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ sv/sensor_average_calibrate_normalize.sv @@
// Six-channel sensor averager with min/max calibration and percent levels.
// req_ carries one converter sample per channel; every SAMPLES_PER_AVERAGE-th
// item closes an averaging window. In calibrate mode (0) and run mode (1) that
// item produces one rsp_ item; in mode 2 or 3 it only clears the sums.
// csr_ writes mode, first channel and last channel; the user must write
// them only while the block is idle, which the block does not enforce.
// Items that do not close a window are taken back to back. A closing item
// runs a sequencer over the channels with one shared bit-serial divider (one
// quotient bit per cycle, NUM_W bits, 19 at the default): each processed
// channel gets its average from it and, in run mode, a further level
// division when the average lies within min..max and max differs from min.
// req_tready stays low while the sequencer runs. The result waits in an
// output register while new items are taken; if it is still waiting when the
// next result is ready, the sequencer holds in its last state and takes no
// new item until the earlier result is taken.
// Synchronous reset clears sums, count, calibration (min = all ones, max = 0),
// averages, levels, difference extremes and flags; mode 0, channels 0 to 5.
module sensor_average_calibrate_normalize #(
   parameter int SAMPLES_PER_AVERAGE = 16,
   parameter int SAMPLE_BITS         = 12,
   parameter int FULL_SCALE          = 100
) (
   input  logic clock,
   input  logic reset,
   // sample0 .. sample5, SAMPLE_BITS each, zero pad to bytes
   input  logic [((sacn_pkg::CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // value0 .. value5, left_lost, right_lost, diff_max, diff_min, zero pad
   output logic [sacn_pkg::RSP_W-1:0]             rsp_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_we,
   input  logic [sacn_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [sacn_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import sacn_pkg::*;

   localparam int CNT_W   = $clog2(SAMPLES_PER_AVERAGE);
   localparam int ACC_W   = SAMPLE_BITS + CNT_W;
   localparam int LEVEL_W = $clog2(FULL_SCALE + 1);
   localparam int PROD_W  = SAMPLE_BITS + LEVEL_W;
   localparam int NUM_W   = (ACC_W > PROD_W) ? ACC_W : PROD_W;
   localparam int SPA_W   = $clog2(SAMPLES_PER_AVERAGE + 1);
   localparam int DEN_W   = (SAMPLE_BITS > SPA_W) ? SAMPLE_BITS : SPA_W;
   localparam int DIFF_W  = SAMPLE_BITS + 2;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CHAN      = 3'd1;
   localparam logic [2:0] ST_AVG_WAIT  = 3'd2;
   localparam logic [2:0] ST_LVL_MUL   = 3'd3;
   localparam logic [2:0] ST_LVL_START = 3'd4;
   localparam logic [2:0] ST_LVL_WAIT  = 3'd5;
   localparam logic [2:0] ST_FLAGS     = 3'd6;
   localparam logic [2:0] ST_FINISH    = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CH_W-1:0]        ch_ff, ch_in;
   logic [ACC_W-1:0]       acc_ff [CHANNELS];
   logic [ACC_W-1:0]       acc_in [CHANNELS];
   logic [ACC_W-1:0]       sum_ff [CHANNELS];
   logic [ACC_W-1:0]       sum_in [CHANNELS];
   logic [SAMPLE_BITS-1:0] avg_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] avg_in [CHANNELS];
   logic [SAMPLE_BITS-1:0] min_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] min_in [CHANNELS];
   logic [SAMPLE_BITS-1:0] max_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] max_in [CHANNELS];
   logic [LEVEL_W-1:0]     lvl_ff [CHANNELS];
   logic [LEVEL_W-1:0]     lvl_in [CHANNELS];
   logic [SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [DIFF_W-1:0] dmax_ff, dmax_in, dmin_ff, dmin_in;
   logic                   lost2_ff, lost2_in, lost5_ff, lost5_in;
   logic                   cent_ff, cent_in, left_ff, left_in, right_ff, right_in;
   logic [1:0]             mode_ff, mode_in;
   logic [CH_W-1:0]        first_ff, first_in, last_ff, last_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   div_start;
   logic [NUM_W-1:0]       div_num;
   logic [DEN_W-1:0]       div_den;
   logic [NUM_W-1:0]       div_quo;
   div_stat_type           div_stat;

   logic                   accept;
   logic                   proc_ch;
   logic [SAMPLE_BITS-1:0] q_avg;
   logic [SAMPLE_BITS-1:0] lo, hi;
   logic [LEVEL_W-1:0]     lvl_m;
   logic [DIFF_W-1:0]      s23, s45;
   logic signed [DIFF_W-1:0] d;

   sacn_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ch_in        = ch_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      prod_in      = prod_ff;
      dmax_in      = dmax_ff;
      dmin_in      = dmin_ff;
      lost2_in     = lost2_ff;
      lost5_in     = lost5_ff;
      cent_in      = cent_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mode_in      = mode_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      div_start    = 1'b0;
      div_num      = NUM_W'(sum_ff[ch_ff]);
      div_den      = DEN_W'(SAMPLES_PER_AVERAGE);
      q_avg        = div_quo[SAMPLE_BITS-1:0];
      lo           = min_ff[ch_ff];
      hi           = max_ff[ch_ff];
      proc_ch      = (last_ff > first_ff) && (last_ff < CH_W'(CHANNELS))
                     && (ch_ff >= first_ff) && (ch_ff <= last_ff);
      lvl_m        = (lvl_ff[2] < lvl_ff[5]) ? lvl_ff[2] : lvl_ff[5];
      s23          = DIFF_W'(avg_ff[2]) + DIFF_W'(avg_ff[3]);
      s45          = DIFF_W'(avg_ff[4]) + DIFF_W'(avg_ff[5]);
      d            = signed'(s23 - s45);

      if (csr_we) begin
         unique case (csr_addr)
            CSR_MODE:  mode_in  = csr_wdata[1:0];
            CSR_FIRST: first_in = csr_wdata;
            CSR_LAST:  last_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               for (int k = 0; k < CHANNELS; k++) begin
                  acc_in[k] = acc_ff[k]
                     + ACC_W'(req_tdata[k*SAMPLE_BITS +: SAMPLE_BITS]);
               end
               if (cnt_ff == CNT_W'(SAMPLES_PER_AVERAGE - 1)) begin
                  cnt_in = '0;
                  for (int k = 0; k < CHANNELS; k++) begin
                     sum_in[k] = acc_in[k];
                     acc_in[k] = '0;
                  end
                  if (mode_ff == MODE_CAL || mode_ff == MODE_RUN) begin
                     ch_in    = '0;
                     lost2_in = 1'b0;
                     lost5_in = 1'b0;
                     state_in = ST_CHAN;
                  end
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_CHAN: begin
            if (ch_ff == CH_W'(CHANNELS)) begin
               state_in = ST_FLAGS;
            end else if (proc_ch) begin
               div_start = 1'b1;
               state_in  = ST_AVG_WAIT;
            end else begin
               ch_in = ch_ff + CH_W'(1);
            end
         end
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               avg_in[ch_ff] = q_avg;
               cur_in        = q_avg;
               ch_in         = ch_ff + CH_W'(1);
               state_in      = ST_CHAN;
               if (mode_ff == MODE_CAL) begin
                  if (q_avg < lo) begin
                     min_in[ch_ff] = q_avg;
                  end else if (q_avg > hi) begin
                     max_in[ch_ff] = q_avg;
                  end
               end else if (q_avg >= lo && q_avg <= hi) begin
                  if (hi == lo) begin
                     lvl_in[ch_ff] = '0;
                  end else begin
                     ch_in    = ch_ff;
                     state_in = ST_LVL_MUL;
                  end
               end else if (q_avg > hi) begin
                  lvl_in[ch_ff] = LEVEL_W'(FULL_SCALE);
               end else begin
                  lvl_in[ch_ff] = '0;
                  if (ch_ff == CH_W'(2)) lost2_in = 1'b1;
                  if (ch_ff == CH_W'(5)) lost5_in = 1'b1;
               end
            end
         end
         ST_LVL_MUL: begin
            prod_in  = PROD_W'(cur_ff - lo) * PROD_W'(FULL_SCALE);
            state_in = ST_LVL_START;
         end
         ST_LVL_START: begin
            div_start = 1'b1;
            div_num   = NUM_W'(prod_ff);
            div_den   = DEN_W'(hi - lo);
            state_in  = ST_LVL_WAIT;
         end
         ST_LVL_WAIT: begin
            if (div_stat.done) begin
               lvl_in[ch_ff] = div_quo[LEVEL_W-1:0];
               ch_in         = ch_ff + CH_W'(1);
               state_in      = ST_CHAN;
            end
         end
         ST_FLAGS: begin
            if (mode_ff == MODE_CAL) begin
               if (dmax_ff < d) dmax_in = d;
               if (dmin_ff > d) dmin_in = d;
            end else if (lost2_ff && !lost5_ff && cent_ff) begin
               cent_in = 1'b0; left_in = 1'b1; right_in = 1'b0;
            end else if (!lost2_ff && lost5_ff && cent_ff) begin
               cent_in = 1'b0; left_in = 1'b0; right_in = 1'b1;
            end else if (!lost2_ff && !lost5_ff && lvl_ff[3] > lvl_m
                         && lvl_ff[4] > lvl_m) begin
               cent_in = 1'b1; left_in = 1'b0; right_in = 1'b0;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = '0;
               for (int k = 0; k < CHANNELS; k++) begin
                  rsp_data_in[k*VALUE_W +: VALUE_W] = (mode_ff == MODE_CAL)
                     ? VALUE_W'(avg_ff[k]) : VALUE_W'(lvl_ff[k]);
               end
               rsp_data_in[CHANNELS*VALUE_W]     = left_ff;
               rsp_data_in[CHANNELS*VALUE_W + 1] = right_ff;
               rsp_data_in[CHANNELS*VALUE_W + 2 +: DIFF_OUT_W] =
                  DIFF_OUT_W'(dmax_ff);
               rsp_data_in[CHANNELS*VALUE_W + 2 + DIFF_OUT_W +: DIFF_OUT_W] =
                  DIFF_OUT_W'(dmin_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ch_ff        <= '0;
         dmax_ff      <= '0;
         dmin_ff      <= '0;
         lost2_ff     <= 1'b0;
         lost5_ff     <= 1'b0;
         cent_ff      <= 1'b0;
         left_ff      <= 1'b0;
         right_ff     <= 1'b0;
         mode_ff      <= MODE_CAL;
         first_ff     <= CH_W'(0);
         last_ff      <= CH_W'(CHANNELS - 1);
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            acc_ff[k] <= '0;
            avg_ff[k] <= '0;
            min_ff[k] <= '1;
            max_ff[k] <= '0;
            lvl_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ch_ff        <= ch_in;
         dmax_ff      <= dmax_in;
         dmin_ff      <= dmin_in;
         lost2_ff     <= lost2_in;
         lost5_ff     <= lost5_in;
         cent_ff      <= cent_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         mode_ff      <= mode_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         avg_ff       <= avg_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         lvl_ff       <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      cur_ff      <= cur_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "sensor_average_calibrate_normalize_assert.svh"

   `SACN_ASSERT_IMP(a_div_start_free, clock, reset, div_start, !div_stat.busy)
   `SACN_ASSERT_IMP(a_div_done_waiting, clock, reset, div_stat.done, state_ff == ST_AVG_WAIT || state_ff == ST_LVL_WAIT)
   `SACN_ASSERT_NEXT(a_window_cleared, clock, reset, state_ff == ST_IDLE && state_in != ST_IDLE, cnt_ff == '0)

endmodule
